// ===== rtl/sktbl_pkg.sv =====
// ----------------------------------------------------------------------------
// sktbl_pkg
// Shared types and codes for the sorted key table.
// ----------------------------------------------------------------------------
package sktbl_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 32;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DECIDE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_DONE
    } sktbl_state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } sktbl_ram_ctl_t;

endpackage

// ===== rtl/sktbl_ram.sv =====
// ----------------------------------------------------------------------------
// sktbl_ram
// Single-port key store with registered read data.
// ----------------------------------------------------------------------------
module sktbl_ram #(
    parameter int DEPTH     = sktbl_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = sktbl_pkg::KEY_WIDTH_DEF,
    parameter int ADDR_W    = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  sktbl_pkg::sktbl_ram_ctl_t ctl,
    input  logic [ADDR_W-1:0]     addr,
    input  logic [KEY_WIDTH-1:0]  wr_data,
    output logic [KEY_WIDTH-1:0]  rd_data
);
    import sktbl_pkg::*;

    logic [KEY_WIDTH-1:0] mem [DEPTH];
    logic [KEY_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sorted_key_table.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table
// Ordered table of unsigned keys: search, insert (before equals) and delete.
// ----------------------------------------------------------------------------
// Sequence: a search reads keys from entry 0 up to the first key not below the
//   request key or up to the count; an accepted insert then moves the entries
//   from that position on up by one and writes the key, a delete of a hit key
//   moves the entries above it down by one, and then the result is loaded.
// Requests: one transaction at a time; the next request is taken in the cycle
//   after the result is loaded, spaced by the walk over the single-port key store.
// Reset: rst_n clears the entry count and control; key store is not cleared.
// ----------------------------------------------------------------------------
module sorted_key_table #(
    parameter int DEPTH     = sktbl_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = sktbl_pkg::KEY_WIDTH_DEF,
    parameter int ADDR_W    = $clog2(DEPTH),
    parameter int COUNT_W   = $clog2(DEPTH + 1),
    parameter int IN_W      = ((sktbl_pkg::OP_W + KEY_WIDTH + 7) / 8) * 8,
    parameter int OUT_W     = ((1 + sktbl_pkg::STATUS_W + COUNT_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // operation, key
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // found, status, entries
);
    import sktbl_pkg::*;

    sktbl_state_t         state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [COUNT_W-1:0]   idx_reg, idx_next;
    logic [COUNT_W-1:0]   pos_reg, pos_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 hit_reg, hit_next;
    logic [STATUS_W-1:0]  status_reg, status_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg, out_found_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [COUNT_W-1:0]   out_entries_reg, out_entries_next;

    sktbl_ram_ctl_t       ram_ctl;
    logic [ADDR_W-1:0]    ram_addr;
    logic [KEY_WIDTH-1:0] ram_wr_data;
    logic [KEY_WIDTH-1:0] ram_rd_data;

    logic                 in_fire;
    logic                 out_free;
    logic [COUNT_W-1:0]   idx_inc;
    logic [COUNT_W-1:0]   idx_dec;

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign idx_inc  = idx_reg + COUNT_W'(1);
    assign idx_dec  = idx_reg - COUNT_W'(1);

    sktbl_ram #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH),
        .ADDR_W    (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .ctl     (ram_ctl),
        .addr    (ram_addr),
        .wr_data (ram_wr_data),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                state_next = (idx_reg < count_reg) ? S_SRCH_CMP : S_DECIDE;
            end
            S_SRCH_CMP:
            begin
                state_next = (ram_rd_data < key_reg) ? S_SRCH_RD : S_DECIDE;
            end
            S_DECIDE:
            begin
                priority if (op_reg == OP_INSERT && count_reg < COUNT_W'(DEPTH))
                begin
                    state_next = S_INS_RD;
                end
                else if (op_reg == OP_DELETE && hit_reg)
                begin
                    state_next = S_DEL_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_INS_RD:
            begin
                state_next = (idx_reg > pos_reg) ? S_INS_WR : S_DONE;
            end
            S_INS_WR:
            begin
                state_next = S_INS_RD;
            end
            S_DEL_RD:
            begin
                state_next = (idx_inc < count_reg) ? S_DEL_WR : S_DONE;
            end
            S_DEL_WR:
            begin
                state_next = S_DEL_RD;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready         = (state_reg == S_IDLE);
        op_next          = op_reg;
        key_next         = key_reg;
        idx_next         = idx_reg;
        pos_next         = pos_reg;
        count_next       = count_reg;
        hit_next         = hit_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_found_next   = out_found_reg;
        out_status_next  = out_status_reg;
        out_entries_next = out_entries_reg;
        ram_ctl          = '0;
        ram_addr         = idx_reg[ADDR_W-1:0];
        ram_wr_data      = ram_rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next  = s_tdata[OP_W-1:0];
                    key_next = s_tdata[OP_W +: KEY_WIDTH];
                    idx_next = '0;
                    hit_next = 1'b0;
                end
            end
            S_SRCH_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    ram_ctl.rd_en = 1'b1;
                end
                else
                begin
                    pos_next = idx_reg;
                    hit_next = 1'b0;
                end
            end
            S_SRCH_CMP:
            begin
                if (ram_rd_data < key_reg)
                begin
                    idx_next = idx_inc;
                end
                else
                begin
                    pos_next = idx_reg;
                    hit_next = (ram_rd_data == key_reg);
                end
            end
            S_DECIDE:
            begin
                idx_next = (op_reg == OP_INSERT) ? count_reg : pos_reg;
                priority if (op_reg == OP_INSERT)
                begin
                    status_next = (count_reg < COUNT_W'(DEPTH)) ? STAT_OK : STAT_FULL;
                end
                else if (op_reg == OP_DELETE)
                begin
                    priority if (count_reg == '0)
                        status_next = STAT_EMPTY;
                    else if (!hit_reg)
                        status_next = STAT_MISSING;
                    else
                        status_next = STAT_OK;
                end
                else
                begin
                    priority if (hit_reg)
                        status_next = STAT_OK;
                    else if (count_reg == '0)
                        status_next = STAT_EMPTY;
                    else
                        status_next = STAT_MISSING;
                end
            end
            S_INS_RD:
            begin
                if (idx_reg > pos_reg)
                begin
                    ram_ctl.rd_en = 1'b1;
                    ram_addr      = idx_dec[ADDR_W-1:0];
                end
                else
                begin
                    ram_ctl.wr_en = 1'b1;
                    ram_wr_data   = key_reg;
                    count_next    = count_reg + COUNT_W'(1);
                end
            end
            S_INS_WR:
            begin
                ram_ctl.wr_en = 1'b1;
                idx_next      = idx_dec;
            end
            S_DEL_RD:
            begin
                if (idx_inc < count_reg)
                begin
                    ram_ctl.rd_en = 1'b1;
                    ram_addr      = idx_inc[ADDR_W-1:0];
                end
                else
                begin
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            S_DEL_WR:
            begin
                ram_ctl.wr_en = 1'b1;
                idx_next      = idx_inc;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_found_next   = hit_reg;
                    out_status_next  = status_reg;
                    out_entries_next = count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        key_reg         <= key_next;
        idx_reg         <= idx_next;
        pos_reg         <= pos_next;
        hit_reg         <= hit_next;
        status_reg      <= status_next;
        out_found_reg   <= out_found_next;
        out_status_reg  <= out_status_next;
        out_entries_reg <= out_entries_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_entries_reg, out_status_reg, out_found_reg});

endmodule

// ===== tb/sorted_key_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_tb
// Streams search, insert and delete requests into the sorted key table and
// checks every response against an in-bench ordered table. The sender runs
// in bursts with gaps, the receiver stalls on its own pattern, and the
// request mix swings between filling and draining so that both the full
// and the empty table are reached many times.
// ----------------------------------------------------------------------------
module sorted_key_table_tb;
    import sktbl_pkg::*;

    localparam int DEPTH   = DEPTH_DEF;
    localparam int KEY_W   = KEY_WIDTH_DEF;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int IN_W    = ((OP_W + KEY_W + 7) / 8) * 8;
    localparam int OUT_W   = ((1 + STATUS_W + COUNT_W + 7) / 8) * 8;
    localparam int RANDOM_REQUESTS = 1600;

    typedef struct packed {
        logic                found;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entries;
    } table_result_t;

    class key_table_scoreboard;
        logic [KEY_W-1:0] keys [DEPTH];
        int unsigned      count;
        table_result_t    pending_results [$];
        int               errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
            int unsigned   pos;
            int unsigned   i;
            bit            hit;
            table_result_t r;
            pos = 0;
            while (pos < count && keys[pos] < key)
                pos++;
            hit = (pos < count) && (keys[pos] == key);
            if (op == OP_INSERT) begin
                if (count >= DEPTH) begin
                    r.status = STAT_FULL;
                end
                else begin
                    for (i = count; i > pos; i--)
                        keys[i] = keys[i - 1];
                    keys[pos] = key;
                    count++;
                    r.status = STAT_OK;
                end
            end
            else if (op == OP_DELETE) begin
                if (count == 0) begin
                    r.status = STAT_EMPTY;
                end
                else if (!hit) begin
                    r.status = STAT_MISSING;
                end
                else begin
                    for (i = pos; i + 1 < count; i++)
                        keys[i] = keys[i + 1];
                    count--;
                    r.status = STAT_OK;
                end
            end
            else begin
                // search, and the unused code that behaves as one
                if (hit)
                    r.status = STAT_OK;
                else if (count == 0)
                    r.status = STAT_EMPTY;
                else
                    r.status = STAT_MISSING;
            end
            r.found   = hit;
            r.entries = count[COUNT_W-1:0];
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [OUT_W-1:0] tdata);
            table_result_t exp_r;
            logic                found;
            logic [STATUS_W-1:0] status;
            logic [COUNT_W-1:0]  entries;
            found   = tdata[0];
            status  = tdata[STATUS_W:1];
            entries = tdata[STATUS_W+COUNT_W:STATUS_W+1];
            if (pending_results.size() == 0) begin
                $error("unexpected response transaction: tdata %h", tdata);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (found !== exp_r.found) begin
                $error("found mismatch: expected %0d, actual %0d", exp_r.found, found);
                errors++;
            end
            if (status !== exp_r.status) begin
                $error("status mismatch: expected %0d, actual %0d", exp_r.status, status);
                errors++;
            end
            if (entries !== exp_r.entries) begin
                $error("entries mismatch: expected %0d, actual %0d", exp_r.entries, entries);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;    // operation, key
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;    // found, status, entries

    key_table_scoreboard sb;
    int                  burst_left;
    int                  rx_cycle;
    int                  rx_mode;

    sorted_key_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: free-running, random and heavily stalled stretches
    always @(negedge clk)
    begin
        if (rx_cycle % 100 == 0)
            rx_mode = $urandom_range(0, 2);
        rx_cycle++;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // call at a falling edge; returns at a falling edge
    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
        s_tdata  <= IN_W'({key, op});
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(op, key);
        @(negedge clk);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 10);
        end
        else begin
            burst_left--;
        end
    endtask

    function automatic logic [KEY_W-1:0] pick_key(input int stored_pct);
        if (sb.count > 0 && $urandom_range(0, 99) < stored_pct)
            return sb.keys[$urandom_range(0, sb.count - 1)];
        case ($urandom_range(0, 7))
            0, 1, 2: return KEY_W'($urandom_range(0, 7));
            3:       return '1 - KEY_W'($urandom_range(0, 3));
            4:       return '0;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [OP_W-1:0] op;
        logic [KEY_W-1:0] key;
        int               fill_phase;
        int               n;
        int               roll;

        sb         = new();
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        burst_left = 0;
        rx_cycle   = 0;
        rx_mode    = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty table cases
        send_request(OP_SEARCH, 32'd5);
        send_request(OP_DELETE, 32'd5);
        send_request(2'd3, 32'd0);
        // extremes, duplicates, hit and miss
        send_request(OP_INSERT, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'd0);
        send_request(OP_INSERT, 32'd7);
        send_request(OP_INSERT, 32'd7);
        send_request(OP_SEARCH, 32'd7);
        send_request(OP_SEARCH, 32'd8);
        send_request(2'd3, 32'd7);
        send_request(OP_DELETE, 32'd9);
        send_request(OP_DELETE, 32'd7);
        // fill to capacity, then refuse inserts of present and absent keys
        n = 1;
        while (sb.count < DEPTH) begin
            send_request(OP_INSERT, 32'h5555_5555 ^ (32'd1 << n));
            n++;
        end
        send_request(OP_INSERT, 32'd1);
        send_request(OP_INSERT, 32'd0);
        send_request(OP_SEARCH, 32'hFFFF_FFFF);

        fill_phase = 1;
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 80 == 0)
                fill_phase = !fill_phase;
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                op  = 2'd3;
                key = pick_key(50);
            end
            else if (roll < 25) begin
                op  = OP_SEARCH;
                key = pick_key(50);
            end
            else if ((roll < 80) == (fill_phase != 0)) begin
                op  = OP_INSERT;
                key = pick_key(30);
            end
            else begin
                op  = OP_DELETE;
                key = pick_key(70);
            end
            send_request(op, key);
        end

        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
